FILE: sv/u2u_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u_pkg
// Shared types and constants for the UTF-8 to UTF-16 (BMP) decoder.
// ----------------------------------------------------------------------------
package u2u_pkg;

    localparam logic [15:0] CAP_RESET     = 16'hFFFF;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
    localparam logic [1:0]  PEND_TWO_BYTE = 2'd1;
    localparam logic [1:0]  PEND_THREE    = 2'd2;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        logic        unit_valid;
        logic [15:0] code_unit;
        logic [15:0] unit_count;
        logic        string_done;
    } out_item_t;

endpackage

FILE: sv/u2u_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u_in_stage
// Input register: captures one byte transfer and holds it until decoded.
// ----------------------------------------------------------------------------
module u2u_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  u2u_pkg::in_item_t s_item,
    output logic              item_valid,
    input  logic              item_take,
    output u2u_pkg::in_item_t item
);

    logic              valid_reg;
    logic              valid_next;
    u2u_pkg::in_item_t item_reg;

    // free slot, or the held item leaves this cycle
    assign s_ready    = !valid_reg || item_take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !item_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: sv/u2u_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u_decode
// Sequence decoder: string state, capacity register and one result per byte.
// ----------------------------------------------------------------------------
module u2u_decode (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic               step,
    input  u2u_pkg::in_item_t  item,
    output u2u_pkg::out_item_t result
);

    logic [15:0] cap_reg;
    logic [1:0]  pend_reg;
    logic [1:0]  pend_next;
    logic [15:0] part_reg;
    logic [15:0] part_next;
    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic        valid;
    logic [15:0] unit;
    logic [7:0]  b;

    assign b = item.byte_in;

    always_comb begin
        valid      = 1'b0;
        unit       = 16'd0;
        pend_next  = pend_reg;
        part_next  = part_reg;
        if (pend_reg != 2'd0) begin
            part_next = {part_reg[9:0], b[5:0]};
            pend_next = pend_reg - 2'd1;
            if (pend_next == 2'd0) begin
                valid     = 1'b1;
                unit      = part_next;
                part_next = 16'd0;
            end
        end else if (count_reg < cap_reg) begin
            if (!b[7]) begin
                valid = 1'b1;
                unit  = {8'd0, b};
            end else if (b[7:5] == 3'b111) begin
                part_next = {12'd0, b[3:0]};
                pend_next = u2u_pkg::PEND_THREE;
            end else if (b[7:6] == 2'b11) begin
                part_next = {11'd0, b[4:0]};
                pend_next = u2u_pkg::PEND_TWO_BYTE;
            end
            // stray continuation byte is dropped
        end
        count_next = count_reg;
        if (valid && count_reg != u2u_pkg::COUNT_MAX) begin
            count_next = count_reg + 16'd1;
        end
    end

    assign result.unit_valid  = valid;
    assign result.code_unit   = unit;
    assign result.unit_count  = count_next;
    assign result.string_done = item.end_of_string;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= u2u_pkg::CAP_RESET;
            pend_reg  <= 2'd0;
            part_reg  <= 16'd0;
            count_reg <= 16'd0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (step) begin
                if (item.end_of_string) begin
                    pend_reg  <= 2'd0;
                    part_reg  <= 16'd0;
                    count_reg <= 16'd0;
                end else begin
                    pend_reg  <= pend_next;
                    part_reg  <= part_next;
                    count_reg <= count_next;
                end
            end
        end
    end

endmodule

FILE: sv/u2u_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u_out_stage
// Result register: holds one decoded result until the downstream transfer.
// ----------------------------------------------------------------------------
module u2u_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  u2u_pkg::out_item_t result,
    output logic               space,
    output logic               m_valid,
    input  logic               m_ready,
    output u2u_pkg::out_item_t m_item
);

    logic               valid_reg;
    logic               valid_next;
    u2u_pkg::out_item_t item_reg;

    assign space      = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load) begin
            item_reg <= result;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule

FILE: sv/utf8_to_utf16_bmp_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_bmp_decoder
// UTF-8 byte stream in, one 16-bit code unit result per byte out.
// Each byte passes through the input register and then the result register.
// Accepts one byte per cycle unless m_ready stalls the result register; the string state updates as each byte advances.
// Reset: synchronous active-low aresetn empties both stages, clears the
// string state and sets output_capacity to 65535.
// ----------------------------------------------------------------------------
module utf8_to_utf16_bmp_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    input  logic        s_end_of_string,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_unit_valid,
    output logic [15:0] m_code_unit,
    output logic [15:0] m_unit_count,
    output logic        m_string_done
);

    u2u_pkg::in_item_t  s_item;
    u2u_pkg::in_item_t  held_item;
    u2u_pkg::out_item_t result;
    u2u_pkg::out_item_t m_item;
    logic               held_valid;
    logic               out_space;
    logic               advance;

    assign s_item.byte_in       = s_byte_in;
    assign s_item.end_of_string = s_end_of_string;

    // item moves from input reg to result reg, state updates with it
    assign advance = held_valid && out_space;

    u2u_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (held_valid),
        .item_take  (advance),
        .item       (held_item)
    );

    u2u_decode u_dec (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (advance),
        .item        (held_item),
        .result      (result)
    );

    u2u_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance),
        .result  (result),
        .space   (out_space),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    assign m_unit_valid  = m_item.unit_valid;
    assign m_code_unit   = m_item.code_unit;
    assign m_unit_count  = m_item.unit_count;
    assign m_string_done = m_item.string_done;

endmodule
